### hdl/cslmd_pkg.sv
// Package for the chained shift LED matrix driver.
// Holds the matrix geometry constants, item kind codes and the input item type.
// No dependencies.
`default_nettype none

package cslmd_pkg;

	localparam int COLUMNS = 8;
	localparam int COL_W   = $clog2(COLUMNS);
	localparam int DATA_W  = 8;
	localparam int EN_W    = 8;
	localparam int FUNC_W  = 2;

	localparam logic [DATA_W-1:0] FRAME_RESET = 8'hFF;

	typedef enum logic [FUNC_W-1:0] {
		FUNC_BYTE   = 2'd0,
		FUNC_SELECT = 2'd1,
		FUNC_TICK   = 2'd2
	} func_t;

	typedef struct packed {
		logic [FUNC_W-1:0] func;
		logic [DATA_W-1:0] byte_in;
	} item_t;

endpackage

`default_nettype wire

### hdl/cslmd_in_if.sv
// Input channel of the LED matrix driver: valid/ready plus item kind and serial byte.
// Depends on cslmd_pkg.
`default_nettype none

interface cslmd_in_if
	import cslmd_pkg::*;
;
	logic              valid;
	logic              ready;
	logic [FUNC_W-1:0] func;
	logic [DATA_W-1:0] byte_in;

	modport source (output valid, output func, output byte_in, input ready);
	modport sink (input valid, input func, input byte_in, output ready);
endinterface

`default_nettype wire

### hdl/cslmd_out_if.sv
// Result channel of the LED matrix driver: valid/ready plus shifted byte and scan outputs.
// Depends on cslmd_pkg.
`default_nettype none

interface cslmd_out_if
	import cslmd_pkg::*;
;
	logic              valid;
	logic              ready;
	logic [DATA_W-1:0] shift_out;
	logic [DATA_W-1:0] row_bits;
	logic [EN_W-1:0]   column_enable;

	modport source (output valid, output shift_out, output row_bits, output column_enable,
		input ready);
	modport sink (input valid, input shift_out, input row_bits, input column_enable,
		output ready);
endinterface

`default_nettype wire

### hdl/cslmd_in_stage.sv
// Input register stage: captures one item per cycle, holds it while the core stalls.
// Depends on cslmd_pkg and cslmd_in_if.
`default_nettype none

module cslmd_in_stage
	import cslmd_pkg::*;
(
	input  wire logic   clk,
	input  wire logic   arst_n,
	cslmd_in_if.sink    cmd,
	input  wire logic   take,
	output logic        valid_s1,
	output item_t       item_s1
);

	assign cmd.ready = !valid_s1 || take;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (cmd.ready) begin
			valid_s1 <= cmd.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.valid && cmd.ready) begin
			item_s1.func    <= cmd.func;
			item_s1.byte_in <= cmd.byte_in;
		end
	end

endmodule

`default_nettype wire

### hdl/cslmd_core.sv
// Core: ring, frame store and scan state, updated per item, plus the result register.
// Depends on cslmd_pkg and cslmd_out_if.
`default_nettype none

module cslmd_core
	import cslmd_pkg::*;
(
	input  wire logic   clk,
	input  wire logic   arst_n,
	input  wire logic   valid_s1,
	input  wire item_t  item_s1,
	output logic        take,
	cslmd_out_if.source disp
);

	logic [DATA_W-1:0] ring_q [COLUMNS];
	logic [DATA_W-1:0] frame_q [COLUMNS];
	logic [COL_W-1:0]  ring_pos_q;
	logic [COL_W-1:0]  scan_q;

	logic              out_valid_q;
	logic [DATA_W-1:0] shift_q;
	logic [DATA_W-1:0] rows_q;
	logic [EN_W-1:0]   enable_q;

	logic [COL_W-1:0]  ring_pos_next;
	logic [COL_W-1:0]  scan_next;
	logic [COL_W:0]    rot_sum [COLUMNS];
	logic [COL_W-1:0]  rot_idx [COLUMNS];
	logic [DATA_W-1:0] frame_load [COLUMNS];

	assign take = valid_s1 && (!out_valid_q || disp.ready);

	assign ring_pos_next = (ring_pos_q == COL_W'(COLUMNS - 1)) ? '0 : ring_pos_q + 1'b1;
	assign scan_next     = (scan_q == COL_W'(COLUMNS - 1)) ? '0 : scan_q + 1'b1;

	// rotated, inverted copy of the ring for a select edge
	always_comb begin
		for (int i = 0; i < COLUMNS; i++) begin
			rot_sum[i] = (COL_W+1)'(i) + {1'b0, ring_pos_q};
			if (rot_sum[i] >= (COL_W+1)'(COLUMNS))
				rot_sum[i] = rot_sum[i] - (COL_W+1)'(COLUMNS);
			rot_idx[i]    = rot_sum[i][COL_W-1:0];
			frame_load[i] = ~ring_q[rot_idx[i]];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < COLUMNS; i++) begin
				ring_q[i]  <= '0;
				frame_q[i] <= FRAME_RESET;
			end
			ring_pos_q <= '0;
			scan_q     <= '0;
		end else if (take) begin
			case (func_t'(item_s1.func))
				FUNC_BYTE: begin
					ring_q[ring_pos_q] <= item_s1.byte_in;
					ring_pos_q         <= ring_pos_next;
				end
				FUNC_SELECT: begin
					for (int i = 0; i < COLUMNS; i++)
						frame_q[i] <= frame_load[i];
				end
				FUNC_TICK: begin
					scan_q <= scan_next;
				end
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (take) begin
			out_valid_q <= 1'b1;
		end else if (disp.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (take) begin
			shift_q  <= '0;
			rows_q   <= '0;
			enable_q <= '0;
			case (func_t'(item_s1.func))
				FUNC_BYTE: begin
					shift_q <= ring_q[ring_pos_q];
				end
				FUNC_TICK: begin
					rows_q   <= frame_q[scan_next];
					enable_q <= EN_W'(1) << scan_next;
				end
				default: ;
			endcase
		end
	end

	assign disp.valid         = out_valid_q;
	assign disp.shift_out     = shift_q;
	assign disp.row_bits      = rows_q;
	assign disp.column_enable = enable_q;

endmodule

`default_nettype wire

### hdl/chained_shift_led_matrix_driver_unit.sv
// Top level of the chained shift LED matrix driver.
// Depends on cslmd_pkg, cslmd_in_if, cslmd_out_if, cslmd_in_stage, cslmd_core.
//
// Usage:
//   cmd  : input items (func, byte_in). func 0 is a serial byte, 1 a select rising
//          edge, 2 a refresh tick; code 3 is ignored but still yields a result.
//   disp : one result per item (shift_out, row_bits, column_enable); fields that
//          do not apply to the item's kind are zero.
//   An item taken on cmd passes through an input register and then a result
//   register before it is presented on disp.
//   Throughput is one item per cycle while disp does not stall; cmd stays ready
//   while a result waits as long as the input register is free or moving on.
//   When disp stalls, the result register holds, then the input register fills
//   and cmd.ready drops until disp takes the pending result.
//   Reset (arst_n low) clears the ring to zero, the frame to all ones (LEDs off),
//   the ring position and scan column to zero, and drops both valid flags.
`default_nettype none

module chained_shift_led_matrix_driver_unit
	import cslmd_pkg::*;
(
	input  wire logic   clk,
	input  wire logic   arst_n,
	cslmd_in_if.sink    cmd,
	cslmd_out_if.source disp
);

	logic  valid_s1;
	item_t item_s1;
	logic  take;

	cslmd_in_stage u_in_stage (
		.clk      (clk),
		.arst_n   (arst_n),
		.cmd      (cmd),
		.take     (take),
		.valid_s1 (valid_s1),
		.item_s1  (item_s1)
	);

	cslmd_core u_core (
		.clk      (clk),
		.arst_n   (arst_n),
		.valid_s1 (valid_s1),
		.item_s1  (item_s1),
		.take     (take),
		.disp     (disp)
	);

endmodule

`default_nettype wire

### tb/chained_shift_led_matrix_driver_unit_tb.sv
// Testbench for chained_shift_led_matrix_driver_unit: directed and random items on cmd,
// with every disp result checked against an in-bench model of ring, frame and scan state.
// Depends on cslmd_pkg, cslmd_in_if, cslmd_out_if and the RTL top level.
`timescale 1ns / 100ps

module chained_shift_led_matrix_driver_unit_tb;
	import cslmd_pkg::*;

	localparam logic [FUNC_W-1:0] FUNC_UNDEF = 2'd3;
	localparam int RANDOM_ITEMS = 850;
	localparam int CALM_TAIL    = 100;
	localparam int CYCLE_LIMIT  = 200000;
	localparam int DRAIN_CYCLES = 4;

	typedef struct packed {
		logic [DATA_W-1:0] shift_out;
		logic [DATA_W-1:0] row_bits;
		logic [EN_W-1:0]   column_enable;
	} display_t;

	logic clk;
	logic arst_n;

	cslmd_in_if  cmd_if ();
	cslmd_out_if disp_if ();

	chained_shift_led_matrix_driver_unit uut (
		.clk    (clk),
		.arst_n (arst_n),
		.cmd    (cmd_if),
		.disp   (disp_if)
	);

	logic [DATA_W-1:0] ring_model [COLUMNS];
	logic [DATA_W-1:0] frame_model [COLUMNS];
	int                ring_pos_model;
	int                scan_col_model;

	display_t pending_display [$];
	int       mismatches;
	int       results_seen;
	int       items_sent;
	int       cycles;
	bit       input_idling;
	bit       output_idling;

	initial begin
		clk = 1'b0;
		forever #4 clk = ~clk;
	end

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > CYCLE_LIMIT) begin
			$display("timeout after %0d cycles, %0d results outstanding", cycles,
				pending_display.size());
			$display("chained_shift_led_matrix_driver_unit verification failed");
			$finish;
		end
	end

	function automatic display_t matrix_predict(logic [FUNC_W-1:0] f, logic [DATA_W-1:0] b);
		display_t d;
		d = '0;
		case (f)
			FUNC_BYTE: begin
				d.shift_out = ring_model[ring_pos_model];
				ring_model[ring_pos_model] = b;
				ring_pos_model = (ring_pos_model + 1) % COLUMNS;
			end
			FUNC_SELECT: begin
				for (int i = 0; i < COLUMNS; i++)
					frame_model[i] = ~ring_model[(i + ring_pos_model) % COLUMNS];
			end
			FUNC_TICK: begin
				scan_col_model = (scan_col_model + 1) % COLUMNS;
				d.row_bits = frame_model[scan_col_model];
				d.column_enable = (scan_col_model < EN_W) ? EN_W'(1 << scan_col_model) : '0;
			end
			default: ;
		endcase
		return d;
	endfunction

	// drives at the falling edge, takes acceptance at the rising edge
	task automatic send_item(logic [FUNC_W-1:0] f, logic [DATA_W-1:0] b);
		if (input_idling && $urandom_range(0, 3) == 0) begin
			cmd_if.valid <= 1'b0;
			repeat ($urandom_range(1, 5)) @(negedge clk);
		end
		cmd_if.valid   <= 1'b1;
		cmd_if.func    <= f;
		cmd_if.byte_in <= b;
		@(posedge clk);
		while (!cmd_if.ready) @(posedge clk);
		pending_display.push_back(matrix_predict(f, b));
		if (f != FUNC_UNDEF) items_sent++;
		@(negedge clk);
	endtask

	initial begin
		disp_if.ready = 1'b0;
		@(posedge arst_n);
		forever begin
			@(negedge clk);
			if (output_idling && $urandom_range(0, 5) == 0) begin
				disp_if.ready <= 1'b0;
				repeat ($urandom_range(1, 5)) @(negedge clk);
			end
			disp_if.ready <= 1'b1;
		end
	end

	always @(posedge clk) begin
		display_t got;
		display_t want;
		if (arst_n && disp_if.valid && disp_if.ready) begin
			got = '{disp_if.shift_out, disp_if.row_bits, disp_if.column_enable};
			results_seen++;
			if (pending_display.size() == 0) begin
				mismatches++;
				if (mismatches <= 10)
					$display("unexpected result shift=%h rows=%h en=%h", got.shift_out,
						got.row_bits, got.column_enable);
			end else begin
				want = pending_display.pop_front();
				if (got !== want) begin
					mismatches++;
					if (mismatches <= 10)
						$display("result %0d: shift=%h/%h rows=%h/%h en=%h/%h (exp/got)",
							results_seen, want.shift_out, got.shift_out, want.row_bits,
							got.row_bits, want.column_enable, got.column_enable);
				end
			end
		end
	end

	// first tick shows column 1; frame is all off after reset
	task automatic test_reset_frame();
		for (int i = 0; i < COLUMNS; i++)
			send_item(FUNC_TICK, 8'h00);
	endtask

	task automatic test_shift_chain();
		logic [DATA_W-1:0] pattern [9] = '{8'h00, 8'hFF, 8'h01, 8'h80, 8'hA5, 8'h5A,
			8'h3C, 8'hC3, 8'h7E};
		foreach (pattern[i])
			send_item(FUNC_BYTE, pattern[i]);
		send_item(FUNC_SELECT, 8'hFF);
		send_item(FUNC_TICK, 8'hFF);
		send_item(FUNC_TICK, 8'h00);
	endtask

	task automatic test_undefined_kind();
		send_item(FUNC_UNDEF, 8'hFF);
		send_item(FUNC_UNDEF, 8'h00);
		send_item(FUNC_TICK, 8'h55);
		send_item(FUNC_SELECT, 8'h00);
		send_item(FUNC_TICK, 8'hAA);
	endtask

	// mostly whole frames: bytes, select, then a scan; the rest is loose noise
	task automatic test_random_frames();
		int n;
		while (items_sent < RANDOM_ITEMS) begin
			if (items_sent >= RANDOM_ITEMS - CALM_TAIL) begin
				input_idling  = 1'b0;
				output_idling = 1'b0;
			end else if ($urandom_range(0, 7) == 0) begin
				input_idling  = ~input_idling;
				output_idling = ~output_idling;
			end
			if ($urandom_range(0, 9) < 7) begin
				n = ($urandom_range(0, 3) == 0) ? $urandom_range(1, 2 * COLUMNS) : COLUMNS;
				repeat (n) send_item(FUNC_BYTE, DATA_W'($urandom_range(0, 255)));
				send_item(FUNC_SELECT, DATA_W'($urandom_range(0, 255)));
				repeat ($urandom_range(1, COLUMNS + 2))
					send_item(FUNC_TICK, DATA_W'($urandom_range(0, 255)));
			end else begin
				repeat ($urandom_range(1, 4))
					send_item(FUNC_W'($urandom_range(0, 3)), DATA_W'($urandom_range(0, 255)));
			end
		end
	endtask

	initial begin
		arst_n         = 1'b0;
		cmd_if.valid   = 1'b0;
		cmd_if.func    = FUNC_BYTE;
		cmd_if.byte_in = '0;
		mismatches     = 0;
		results_seen   = 0;
		items_sent     = 0;
		input_idling   = 1'b1;
		output_idling  = 1'b1;
		ring_pos_model = 0;
		scan_col_model = 0;
		for (int i = 0; i < COLUMNS; i++) begin
			ring_model[i]  = '0;
			frame_model[i] = FRAME_RESET;
		end
		repeat (5) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		test_reset_frame();
		test_shift_chain();
		test_undefined_kind();
		items_sent = 0;
		test_random_frames();
		cmd_if.valid <= 1'b0;

		while (pending_display.size() != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);

		$display("ran %0d random items plus directed ones (bytes, selects, ticks, code 3)",
			items_sent);
		$display("%0d results checked, %0d mismatches", results_seen, mismatches);
		if (mismatches == 0)
			$display("chained_shift_led_matrix_driver_unit verification clean");
		else
			$display("chained_shift_led_matrix_driver_unit verification failed");
		$finish;
	end

endmodule

### files.f
hdl/cslmd_pkg.sv
hdl/cslmd_in_if.sv
hdl/cslmd_out_if.sv
hdl/cslmd_in_stage.sv
hdl/cslmd_core.sv
hdl/chained_shift_led_matrix_driver_unit.sv
tb/chained_shift_led_matrix_driver_unit_tb.sv
